@@ hdl/olad_pkg.sv @@
// shared types and constants for the ordered list block
// no dependencies; imported by every module of the block except olad_ram
`default_nettype none

package olad_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned ID_W           = 32;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_LISTED   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DEL_RD,
    S_DEL_CHK,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    in_load;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    rd_next;
    logic    wr_en;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    logic    out_last;
  } olad_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    match;
    logic    idx_last;
    logic    out_free;
  } olad_sts_t;

endpackage

`default_nettype wire

@@ hdl/olad_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module olad_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/olad_datapath.sv @@
// datapath: entry ram, count and index registers, item latch, output register
// depends on olad_pkg and olad_ram
`default_nettype none

module olad_datapath #(
  parameter int unsigned LIST_DEPTH = olad_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [olad_pkg::ID_W-1:0]     s_tdata_i,
  input  wire logic [olad_pkg::OP_W-1:0]     s_tuser_i,
  output      logic [olad_pkg::ID_W-1:0]     m_tdata_o,
  output      logic [olad_pkg::STATUS_W-1:0] m_tuser_o,
  output      logic                        m_tlast_o,
  output      logic                        m_tvalid_o,
  input  wire logic                        m_tready_i,
  input  wire olad_pkg::olad_cmd_t         cmd_i,
  output      olad_pkg::olad_sts_t         sts_o
);

  import olad_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic [ID_W-1:0] id_q;
  opcode_e         op_q;
  logic [CW-1:0]   cnt_d, cnt_q;
  logic [AW-1:0]   idx_d, idx_q;
  logic [AW-1:0]   waddr, raddr;
  logic [ID_W-1:0] wdata, rdata;
  logic            valid_q;
  logic [ID_W-1:0] val_q, val_d;
  status_e         stat_q;
  logic            last_q;
  logic            out_free;

  olad_ram #(
    .WIDTH (ID_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign waddr = cmd_i.wr_shift ? idx_q : cnt_q[AW-1:0];
  assign wdata = cmd_i.wr_shift ? rdata : id_q;
  assign raddr = cmd_i.rd_next ? idx_q + AW'(1) : idx_q;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      id_q <= s_tdata_i;
      op_q <= opcode_e'(s_tuser_i);
    end
  end

  // output register
  assign out_free = !valid_q || m_tready_i;

  always_comb begin
    unique case (cmd_i.out_status)
      ST_EMPTY:  val_d = '0;
      ST_LISTED: val_d = rdata;
      default:   val_d = id_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      val_q  <= val_d;
      stat_q <= cmd_i.out_status;
      last_q <= cmd_i.out_last;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = val_q;
  assign m_tuser_o  = stat_q;
  assign m_tlast_o  = last_q;

  assign sts_o.op       = op_q;
  assign sts_o.full     = (cnt_q == CW'(LIST_DEPTH));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.match    = (rdata == id_q);
  assign sts_o.idx_last = ((CW'(idx_q) + CW'(1)) == cnt_q);
  assign sts_o.out_free = out_free;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LIST_DEPTH))
    else $error("entry count above depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output overwritten while stalled");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (cnt_q != CW'(LIST_DEPTH)) && !cmd_i.cnt_dec)
    else $error("append into full list");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("bad count after delete");
`endif

endmodule

`default_nettype wire

@@ hdl/olad_ctrl.sv @@
// controller state machine: sequences append, delete search and shift, dump
// depends on olad_pkg
`default_nettype none

module olad_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output      logic                s_tready_o,
  output      olad_pkg::olad_cmd_t cmd_o,
  input  wire olad_pkg::olad_sts_t sts_i
);

  import olad_pkg::*;

  state_e  state_d, state_q;
  status_e resp_d, resp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts_i.op)
          OP_APPEND: state_d = S_RESP;
          OP_DELETE: state_d = sts_i.empty ? S_RESP : S_DEL_RD;
          OP_DUMP:   state_d = sts_i.empty ? S_RESP : S_DUMP_RD;
          default:   state_d = S_IDLE;
        endcase
      end
      S_DEL_RD: state_d = S_DEL_CHK;
      S_DEL_CHK: begin
        priority if (sts_i.match) state_d = S_SHIFT_CHK;
        else if (sts_i.idx_last)  state_d = S_RESP;
        else                      state_d = S_DEL_RD;
      end
      S_SHIFT_CHK: state_d = sts_i.idx_last ? S_RESP : S_SHIFT_RD;
      S_SHIFT_RD:  state_d = S_SHIFT_WR;
      S_SHIFT_WR:  state_d = S_SHIFT_CHK;
      S_DUMP_RD:   state_d = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (sts_i.out_free) state_d = sts_i.idx_last ? S_IDLE : S_DUMP_RD;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = resp_q;
    cmd_o.out_last   = 1'b1;
    resp_d           = resp_q;
    s_tready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.in_load = s_tvalid_i;
      end
      S_DISPATCH: begin
        unique case (sts_i.op)
          OP_APPEND: begin
            if (sts_i.full) begin
              resp_d = ST_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.cnt_inc = 1'b1;
              resp_d        = ST_INSERTED;
            end
          end
          OP_DELETE, OP_DUMP: begin
            if (sts_i.empty) resp_d = ST_EMPTY;
            else             cmd_o.idx_clr = 1'b1;
          end
          default: ;
        endcase
      end
      S_DEL_RD: cmd_o.rd_en = 1'b1;
      S_DEL_CHK: begin
        if (!sts_i.match) begin
          if (sts_i.idx_last) resp_d = ST_NOTFOUND;
          else                cmd_o.idx_inc = 1'b1;
        end
      end
      S_SHIFT_CHK: begin
        if (sts_i.idx_last) begin
          cmd_o.cnt_dec = 1'b1;
          resp_d        = ST_DELETED;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      S_DUMP_RD: cmd_o.rd_en = 1'b1;
      S_DUMP_OUT: begin
        cmd_o.out_status = ST_LISTED;
        cmd_o.out_last   = sts_i.idx_last;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end
      end
      S_RESP: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !cmd_o.out_load && !cmd_o.wr_en)
    else $error("datapath busy while taking an item");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tready_o && s_tvalid_i) |=> state_q == S_DISPATCH)
    else $error("accepted item not dispatched");

  a_shift_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT_RD |=> cmd_o.wr_en && cmd_o.wr_shift)
    else $error("shift read not followed by write");
`endif

endmodule

`default_nettype wire

@@ hdl/ordered_list_append_delete_dump.sv @@
// ordered list of 32-bit ids with append, delete of first match and dump
// input items arrive on the s_axis channel: tuser is the opcode, tdata the id
// results leave on the m_axis channel: tuser is the status, tdata the value,
// tlast marks the final result of an item
// one item is processed at a time; s_axis_tready_o is high only while idle
// steps from acceptance to the result being loaded:
//   append: dispatch writes the entry, then the response state loads the result
//   delete: a read and a check per entry searched, and when found a check, a read
//   and a write per entry moved up, then the response state loads the result
//   dump: a read, then the result is loaded, for each entry in turn
// s_axis_tready_o returns the cycle after the last result is loaded
// an item that causes no result returns from dispatch straight to idle
// results sit in an output register; a stall there holds the sequencer
// while the next item can still be accepted once the previous one finishes
// reset empties the list at once; the entry ram itself is not cleared
// depends on olad_pkg, olad_ctrl, olad_datapath, olad_ram
`default_nettype none

module ordered_list_append_delete_dump #(
  parameter int unsigned LIST_DEPTH = olad_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  input  wire logic [olad_pkg::ID_W-1:0]     s_axis_tdata_i,  // item_id
  input  wire logic [olad_pkg::OP_W-1:0]     s_axis_tuser_i,  // opcode
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output      logic [olad_pkg::ID_W-1:0]     m_axis_tdata_o,  // entry_value
  output      logic [olad_pkg::STATUS_W-1:0] m_axis_tuser_o,  // status
  output      logic                          m_axis_tlast_o
);

  import olad_pkg::*;

  olad_cmd_t cmd;
  olad_sts_t sts;

  olad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  olad_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire
